FILE: design/derq_pkg.sv
`default_nettype none

package derq_pkg;

    // Default sizing of the queue
    localparam int DEPTH_DEF         = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // Fixed beat field widths
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ_AT    = 3'd4,
        CMD_PEEK_FRONT = 3'd5,
        CMD_PEEK_BACK  = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Per-beat result bookkeeping handed from control to the output stage
    typedef struct packed {
        status_t             status;
        logic [FILL_W-1:0]   fill_count;
        logic                empty_flag;
        logic                has_value;
    } rsp_info_t;

endpackage

`default_nettype wire

FILE: design/derq_if.sv
`default_nettype none

interface derq_req_if import derq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] data_in;
    logic [POS_W-1:0]  position;

    modport source (output valid, output command, output data_in, output position,
                    input ready);
    modport sink   (input valid, input command, input data_in, input position,
                    output ready);
endinterface

interface derq_rsp_if import derq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   value_out;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;
    logic                empty_flag;

    modport source (output valid, output value_out, output status, output fill_count,
                    output empty_flag, input ready);
    modport sink   (input valid, input value_out, input status, input fill_count,
                    input empty_flag, output ready);
endinterface

`default_nettype wire

FILE: design/derq_mem.sv
`default_nettype none

module derq_mem import derq_pkg::*; #(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic                     rd_en,
    input  wire logic [ADDR_W-1:0]        addr,
    input  wire logic [ELEMENT_WIDTH-1:0] wr_data,
    output logic      [ELEMENT_WIDTH-1:0] rd_data
);

    logic [ELEMENT_WIDTH-1:0] store_mem [DEPTH];
    logic [ELEMENT_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[addr] <= wr_data;
        end
    end

    // Hold the read word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/derq_ctrl.sv
`default_nettype none

module derq_ctrl import derq_pkg::*; #(
    parameter int DEPTH   = DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [POS_W-1:0]  position,
    output logic                   wr_en,
    output logic                   rd_en,
    output logic      [ADDR_W-1:0] addr,
    output rsp_info_t              info
);

    localparam int LOG_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W = ((ADDR_W > LOG_W) ? ADDR_W : LOG_W) + 1;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(DEPTH);

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    cmd_t              cmd;
    logic [LOG_W-1:0]  logical;
    logic [SUM_W-1:0]  slot_sum;
    logic [SUM_W-1:0]  slot_wrap;
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic              is_full;
    logic              empty_now;
    logic              pos_out;
    logic              do_wr;
    logic              do_rd;
    status_t           status;

    assign cmd       = cmd_t'(command);
    assign is_full   = (count_reg == FULL_CNT);
    assign empty_now = (count_reg == '0);
    assign pos_out   = (LOG_W'(position) >= LOG_W'(count_reg));
    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;

    // Ring position of a logical index: one conditional subtract wraps it
    always_comb
    begin
        unique case (cmd)
            CMD_PUSH_BACK:                logical = LOG_W'(count_reg);
            CMD_POP_BACK, CMD_PEEK_BACK:  logical = LOG_W'(count_reg - 1'b1);
            CMD_READ_AT:                  logical = LOG_W'(position);
            default:                      logical = '0;
        endcase
    end

    assign slot_sum  = SUM_W'(head_reg) + SUM_W'(logical);
    assign slot_wrap = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;
    assign slot      = ADDR_W'(slot_wrap);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        status     = ST_OK;
        do_wr      = 1'b0;
        do_rd      = 1'b0;
        addr       = slot;
        unique case (cmd)
            CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_wr      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_PUSH_FRONT:
            begin
                addr = head_dec;
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_wr      = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK:
            begin
                if (empty_now)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    do_rd = 1'b1;
                    if (cmd == CMD_POP_FRONT)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                    else if (cmd == CMD_POP_BACK)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            CMD_READ_AT:
            begin
                if (empty_now)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_out)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    do_rd = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
        endcase
    end

    assign wr_en = accept && do_wr;
    assign rd_en = accept && do_rd;

    assign info.status     = status;
    assign info.fill_count = FILL_W'(count_next);
    assign info.empty_flag = (count_next == '0);
    assign info.has_value  = do_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/double_ended_ring_queue.sv
`default_nettype none
// Double-ended ring queue over one synchronous element memory.
// A beat's result passes through stage 1 (memory read register) and then the output
// register, which holds while rsp.ready is low; unstalled, beats follow back to back.
// Throughput: one beat per cycle unless rsp.ready stalls; the memory port is touched
// at most once per beat; head pointer and fill count update at the accept edge.
// Reset clears the head pointer, the fill count and the pipeline valids only.

module double_ended_ring_queue import derq_pkg::*; #(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    derq_req_if.sink     req,
    derq_rsp_if.source   rsp
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Control / memory hookup
    logic                     accept;
    logic                     wr_en;
    logic                     rd_en;
    logic [ADDR_W-1:0]        addr;
    logic [ELEMENT_WIDTH-1:0] wr_data;
    logic [ELEMENT_WIDTH-1:0] rd_data;
    rsp_info_t                info;

    // Stage 1: memory read in flight, bookkeeping held alongside
    logic      s1_valid_reg, s1_valid_next;
    rsp_info_t s1_info_reg;
    logic      s1_adv;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg;
    rsp_info_t           out_info_reg;

    // Advance stage 1 whenever the output register is free or being drained;
    // take a new beat whenever stage 1 is empty or moving on.
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    // Keep only the low element bits of the incoming word
    assign wr_data = ELEMENT_WIDTH'(req.data_in);

    derq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .command  (req.command),
        .position (req.position),
        .wr_en    (wr_en),
        .rd_en    (rd_en),
        .addr     (addr),
        .info     (info)
    );

    derq_mem #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .addr    (addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Valid tracking for both stages
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture bookkeeping at accept, merge the read word on the way out.
    // The memory read register holds while stage 1 stalls, since no read issues then.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_info_reg  <= s1_info_reg;
            out_value_reg <= s1_info_reg.has_value ? DATA_W'(rd_data) : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.value_out  = out_value_reg;
    assign rsp.status     = out_info_reg.status;
    assign rsp.fill_count = out_info_reg.fill_count;
    assign rsp.empty_flag = out_info_reg.empty_flag;

`ifndef SYNTHESIS
    // An error beat never carries an element
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> (rsp.value_out == '0))
        else $error("error beat carries nonzero value");

    // A refused push leaves a full, hence nonempty, queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FULL) |-> !rsp.empty_flag)
        else $error("full status on empty queue");

    // An accepted beat always lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost before stage 1");

    // A beat in stage 1 reaches the output register when it advances
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_adv |=> out_valid_reg)
        else $error("stage 1 beat dropped");
`endif

endmodule

`default_nettype wire
